### src/upa_pkg.sv
// Shared types and constants for the uncertainty propagation ALU
package upa_pkg;

    localparam int WordBits = 32;
    localparam int FracBits = 16;
    localparam int OpBits   = 4;
    localparam int SigBits  = 4;
    localparam int StBits   = 2;

    // Widths of the internal numbers
    localparam int SqBits   = 2 * WordBits + 2;          // sum of two squares of (W+1)-bit values
    localparam int RootBits = SqBits / 2;                // isqrt result width
    localparam int DivNBits = 3 * WordBits + FracBits;   // dividend width, covers the widest dividend (|a|*sb << F)
    localparam int DivDBits = 2 * WordBits;              // widest divisor (b*b)

    localparam logic [SigBits-1:0] SigmaReset = SigBits'(3);

    typedef enum logic [OpBits-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_LT  = 4'd4,
        OP_GT  = 4'd5,
        OP_LE  = 4'd6,
        OP_GE  = 4'd7,
        OP_EQ  = 4'd8,
        OP_NE  = 4'd9
    } t_op;

    typedef enum logic [StBits-1:0] {
        ST_OK  = 2'd0,
        ST_SAT = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    // Class of an item as decided by the front part
    typedef enum logic [2:0] {
        CL_ADDSUB,
        CL_MUL,
        CL_DIV,
        CL_DIVZ,
        CL_CMP,
        CL_NONE
    } t_class;

    // Classified item travelling through the queue
    typedef struct packed {
        t_class               cls;
        t_op                  op;
        logic                 an;
        logic                 bn;
        logic [WordBits-1:0]  am;
        logic [WordBits-1:0]  bm;
        logic [WordBits-1:0]  sa;
        logic [WordBits-1:0]  sb;
        logic [WordBits:0]    sum;   // signed add/sub result, one bit wider
        logic                 lt;
        logic                 gt;
    } t_item;

    // Result item
    typedef struct packed {
        logic [WordBits-1:0] value;
        logic [WordBits-1:0] unc;
        logic                cmp;
        logic [StBits-1:0]   status;
    } t_result;

endpackage

### src/upa_front.sv
// Front part: take input items, normalise operands and classify the operation
module upa_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [upa_pkg::OpBits-1:0]     i_op,
    input  logic [upa_pkg::WordBits-1:0]   i_a_value,
    input  logic [upa_pkg::WordBits-1:0]   i_a_unc,
    input  logic [upa_pkg::WordBits-1:0]   i_b_value,
    input  logic [upa_pkg::WordBits-1:0]   i_b_unc,
    output logic                           o_valid,
    input  logic                           i_ready,
    output upa_pkg::t_item                 o_item
);
    import upa_pkg::*;

    logic   r_valid;
    t_item  r_item;
    t_item  n_item;
    logic   w_an;
    logic   w_bn;
    logic [WordBits:0] w_as;
    logic [WordBits:0] w_bs;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Classify and normalise
    always_comb begin
        w_an = i_a_value[WordBits-1];
        w_bn = i_b_value[WordBits-1];
        w_as = {w_an, i_a_value};
        w_bs = {w_bn, i_b_value};
        n_item.op  = t_op'(i_op);
        n_item.an  = w_an;
        n_item.bn  = w_bn;
        n_item.am  = w_an ? (~i_a_value + WordBits'(1)) : i_a_value;
        n_item.bm  = w_bn ? (~i_b_value + WordBits'(1)) : i_b_value;
        n_item.sa  = (i_a_unc == '0) ? WordBits'(1) : i_a_unc;
        n_item.sb  = (i_b_unc == '0) ? WordBits'(1) : i_b_unc;
        n_item.sum = (i_op == OP_ADD) ? (w_as + w_bs) : (w_as - w_bs);
        n_item.lt  = $signed(i_a_value) < $signed(i_b_value);
        n_item.gt  = $signed(i_a_value) > $signed(i_b_value);
        case (i_op)
            OP_ADD, OP_SUB: n_item.cls = CL_ADDSUB;
            OP_MUL:         n_item.cls = CL_MUL;
            OP_DIV:         n_item.cls = (i_b_value == '0) ? CL_DIVZ : CL_DIV;
            OP_LT, OP_GT, OP_LE, OP_GE, OP_EQ, OP_NE: n_item.cls = CL_CMP;
            default:        n_item.cls = CL_NONE;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

### src/upa_queue.sv
// Short queue between front and back parts
module upa_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  upa_pkg::t_item  i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output upa_pkg::t_item  o_item
);
    import upa_pkg::*;

    localparam int Depth = 4;
    localparam int PtrBits = $clog2(Depth);

    t_item                r_mem [Depth];
    logic [PtrBits-1:0]   r_wp;
    logic [PtrBits-1:0]   r_rp;
    logic [PtrBits:0]     r_cnt;
    logic                 w_push;
    logic                 w_pop;

    assign o_ready = r_cnt != (PtrBits+1)'(Depth);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + PtrBits'(1);
            if (w_pop)  r_rp <= r_rp + PtrBits'(1);
            r_cnt <= r_cnt + (PtrBits+1)'(w_push) - (PtrBits+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_item;
    end

endmodule

### src/upa_back.sv
// Back part: pipelined multipliers, dividers and square root producing results
module upa_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [upa_pkg::SigBits-1:0]   i_sigma,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  upa_pkg::t_item                i_item,
    output logic                          o_valid,
    input  logic                          i_ready,
    output upa_pkg::t_result              o_result
);
    import upa_pkg::*;

    localparam int W  = WordBits;
    localparam int F  = FracBits;
    localparam int NB = DivNBits;
    localparam int DB = DivDBits;
    localparam int RB = RootBits;
    localparam int SB = SqBits;
    // Stage counts: product stage, divide, square stage, root, final
    localparam int DivSt  = NB;
    localparam int RootSt = RB;

    // ---------------- stage 1: products ----------------
    typedef struct packed {
        t_class            cls;
        t_op               op;
        logic              neg;
        logic [W:0]        sum;
        logic              lt;
        logic              gt;
        logic [2*W-1:0]    pab;    // |a|*|b|
        logic [2*W-1:0]    pbs;    // |b|*sa
        logic [2*W-1:0]    pas;    // |a|*sb
        logic [2*W-1:0]    pbb;    // b*b
        logic [W-1:0]      am;
        logic [W-1:0]      bm;
        logic [W-1:0]      sa;
        logic [W-1:0]      sb;
    } t_s1;

    // Divider lane: three quotients in parallel, one bit per stage
    typedef struct packed {
        t_class            cls;
        t_op               op;
        logic              neg;
        logic [W:0]        sum;
        logic              lt;
        logic              gt;
        logic [W:0]        p;      // clipped
        logic [W:0]        q;
        logic [2*W-1:0]    vmag;   // value magnitude product path
        logic [NB-1:0]     nv;     // dividend for value
        logic [NB-1:0]     np;
        logic [NB-1:0]     nq;
        logic [NB-1:0]     qv;
        logic [NB-1:0]     qp;
        logic [NB-1:0]     qq;
        logic [DB:0]       rv;
        logic [DB:0]       rp;
        logic [DB:0]       rq;
        logic [W-1:0]      bm;
        logic [DB-1:0]     bb;
        logic [2*W+1:0]    ss;     // sa^2 + sb^2 for compares
    } t_dv;

    logic        w_adv;
    logic        r_v1;
    t_s1         r_s1;
    logic [DivSt:0] r_vd;
    t_dv         r_d [DivSt+1];
    t_dv         w_d [DivSt+1];

    // Whole pipe advances together when the output can take an item
    logic        r_vo;
    t_result     r_out;
    assign o_ready  = w_adv;
    assign o_valid  = r_vo;
    assign o_result = r_out;

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (w_adv) r_v1 <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1.cls <= i_item.cls;
            r_s1.op  <= i_item.op;
            r_s1.neg <= i_item.an ^ i_item.bn;
            r_s1.sum <= i_item.sum;
            r_s1.lt  <= i_item.lt;
            r_s1.gt  <= i_item.gt;
            r_s1.pab <= (2*W)'(i_item.am) * (2*W)'(i_item.bm);
            r_s1.pbs <= (2*W)'(i_item.bm) * (2*W)'(i_item.sa);
            r_s1.pas <= (2*W)'(i_item.am) * (2*W)'(i_item.sb);
            r_s1.pbb <= (2*W)'(i_item.bm) * (2*W)'(i_item.bm);
            r_s1.am  <= i_item.am;
            r_s1.bm  <= i_item.bm;
            r_s1.sa  <= i_item.sa;
            r_s1.sb  <= i_item.sb;
        end
    end

    // ---------------- stage 2: divider entry, square sums for compare ----------------
    function automatic logic [W:0] clip(input logic [2*W+F-1:0] x);
        logic [W:0] r;
        if (x > (2*W+F)'({1'b1, {W{1'b0}}})) r = {1'b1, {W{1'b0}}};
        else r = x[W:0];
        return r;
    endfunction

    always_comb begin
        w_d[0] = '0;
        w_d[0].cls  = r_s1.cls;
        w_d[0].op   = r_s1.op;
        w_d[0].neg  = r_s1.neg;
        w_d[0].sum  = r_s1.sum;
        w_d[0].lt   = r_s1.lt;
        w_d[0].gt   = r_s1.gt;
        w_d[0].bm   = r_s1.bm;
        w_d[0].bb   = r_s1.pbb;
        w_d[0].vmag = r_s1.pab;
        w_d[0].ss   = (2*W+2)'(r_s1.sa) * (2*W+2)'(r_s1.sa)
                    + (2*W+2)'(r_s1.sb) * (2*W+2)'(r_s1.sb);
        w_d[0].nv   = NB'({r_s1.am, {F{1'b0}}});
        w_d[0].np   = NB'({r_s1.sa, {F{1'b0}}});
        w_d[0].nq   = NB'({r_s1.pas, {F{1'b0}}});
        if (r_s1.cls == CL_MUL) begin
            w_d[0].p = clip((2*W+F)'(r_s1.pbs >> F));
            w_d[0].q = clip((2*W+F)'(r_s1.pas >> F));
        end else if (r_s1.cls == CL_ADDSUB) begin
            w_d[0].p = {1'b0, r_s1.sa};
            w_d[0].q = {1'b0, r_s1.sb};
        end
    end

    // Divider stages: restoring division, one quotient bit per stage
    for (genvar g = 0; g < DivSt; g++) begin : g_div
        always_comb begin
            logic [DB:0] tv;
            logic [DB:0] tp;
            logic [DB:0] tq;
            w_d[g+1] = r_d[g];
            tv = {r_d[g].rv[DB-1:0], r_d[g].nv[NB-1-g]};
            tp = {r_d[g].rp[DB-1:0], r_d[g].np[NB-1-g]};
            tq = {r_d[g].rq[DB-1:0], r_d[g].nq[NB-1-g]};
            if (tv >= (DB+1)'(r_d[g].bm)) begin
                w_d[g+1].rv = tv - (DB+1)'(r_d[g].bm);
                w_d[g+1].qv[NB-1-g] = 1'b1;
            end else begin
                w_d[g+1].rv = tv;
            end
            if (tp >= (DB+1)'(r_d[g].bm)) begin
                w_d[g+1].rp = tp - (DB+1)'(r_d[g].bm);
                w_d[g+1].qp[NB-1-g] = 1'b1;
            end else begin
                w_d[g+1].rp = tp;
            end
            if (tq >= {1'b0, r_d[g].bb}) begin
                w_d[g+1].rq = tq - {1'b0, r_d[g].bb};
                w_d[g+1].qq[NB-1-g] = 1'b1;
            end else begin
                w_d[g+1].rq = tq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vd <= '0;
        else if (w_adv) r_vd <= {r_vd[DivSt-1:0], r_v1};
    end

    for (genvar g = 0; g <= DivSt; g++) begin : g_dreg
        always_ff @(posedge i_clk) begin
            if (w_adv) r_d[g] <= w_d[g];
        end
    end

    // ---------------- squares stage ----------------
    typedef struct packed {
        t_class        cls;
        t_op           op;
        logic          neg;
        logic [W:0]    sum;
        logic          lt;
        logic          gt;
        logic [NB-1:0] vq;       // value magnitude quotient (div)
        logic [2*W-1:0] vmag;
        logic [SB-1:0] sq;
        logic [2*W+1:0] ss;
        logic [2*W+1:0] dd;
    } t_sq;

    t_dv         w_dl;
    t_sq         n_sq;
    t_sq         r_sq;
    logic        r_vs;
    logic [W:0]  w_pp;
    logic [W:0]  w_qq;
    logic [W:0]  w_dm;

    assign w_dl = r_d[DivSt];

    always_comb begin
        w_pp = w_dl.p;
        w_qq = w_dl.q;
        if (w_dl.cls == CL_DIV) begin
            w_pp = clip((2*W+F)'(w_dl.qp));
            w_qq = clip((2*W+F)'(w_dl.qq));
        end
        w_dm = w_dl.sum[W] ? (~w_dl.sum + (W+1)'(1)) : w_dl.sum;
        n_sq.cls  = w_dl.cls;
        n_sq.op   = w_dl.op;
        n_sq.neg  = w_dl.neg;
        n_sq.sum  = w_dl.sum;
        n_sq.lt   = w_dl.lt;
        n_sq.gt   = w_dl.gt;
        n_sq.vq   = w_dl.qv;
        n_sq.vmag = w_dl.vmag;
        n_sq.sq   = SB'(w_pp) * SB'(w_pp) + SB'(w_qq) * SB'(w_qq);
        n_sq.ss   = w_dl.ss;
        n_sq.dd   = (2*W+2)'(w_dm) * (2*W+2)'(w_dm);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vs <= 1'b0;
        else if (w_adv) r_vs <= r_vd[DivSt];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) r_sq <= n_sq;
    end

    // ---------------- compare stage: scale by sigma^2 ----------------
    // Root lane
    typedef struct packed {
        t_class         cls;
        t_op            op;
        logic           neg;
        logic [W:0]     sum;
        logic           cmp;
        logic [NB-1:0]  vq;
        logic [2*W-1:0] vmag;
        logic [SB-1:0]  n;
        logic [RB-1:0]  r;
    } t_rt;

    logic [RootSt:0] r_vr;
    t_rt         r_r [RootSt+1];
    t_rt         w_r [RootSt+1];
    logic [2*SigBits-1:0] w_k2;
    logic [2*W+2*SigBits+1:0] w_rhs;
    logic        w_eq;
    logic        w_cmp;

    always_comb begin
        w_k2  = (2*SigBits)'(i_sigma) * (2*SigBits)'(i_sigma);
        w_rhs = (2*W+2*SigBits+2)'(r_sq.ss) * (2*W+2*SigBits+2)'(w_k2);
        w_eq  = w_rhs >= (2*W+2*SigBits+2)'(r_sq.dd);
        case (r_sq.op)
            OP_LT:   w_cmp = r_sq.lt;
            OP_GT:   w_cmp = r_sq.gt;
            OP_LE:   w_cmp = r_sq.lt || w_eq;
            OP_GE:   w_cmp = r_sq.gt || w_eq;
            OP_EQ:   w_cmp = w_eq;
            OP_NE:   w_cmp = !w_eq;
            default: w_cmp = 1'b0;
        endcase
        w_r[0].cls  = r_sq.cls;
        w_r[0].op   = r_sq.op;
        w_r[0].neg  = r_sq.neg;
        w_r[0].sum  = r_sq.sum;
        w_r[0].cmp  = (r_sq.cls == CL_CMP) ? w_cmp : 1'b0;
        w_r[0].vq   = r_sq.vq;
        w_r[0].vmag = r_sq.vmag;
        w_r[0].n    = r_sq.sq;
        w_r[0].r    = '0;
    end

    // Square root stages: one result bit per stage, compare against square of candidate
    for (genvar g = 0; g < RootSt; g++) begin : g_root
        always_comb begin
            logic [RB-1:0] c;
            logic [SB-1:0] c2;
            w_r[g+1] = r_r[g];
            c  = r_r[g].r | (RB'(1) << (RB-1-g));
            c2 = SB'(c) * SB'(c);
            if (r_r[g].n >= c2) w_r[g+1].r = c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vr <= '0;
        else if (w_adv) r_vr <= {r_vr[RootSt-1:0], r_vs};
    end

    for (genvar g = 0; g <= RootSt; g++) begin : g_rreg
        always_ff @(posedge i_clk) begin
            if (w_adv) r_r[g] <= w_r[g];
        end
    end

    // ---------------- final stage: saturate and format ----------------
    t_result     n_out;
    t_rt         w_f;
    logic [NB-1:0] w_mag;
    logic [NB-1:0] w_lim;
    logic [W-1:0]  w_m;
    logic          w_sat;

    assign w_f = r_r[RootSt];

    always_comb begin
        n_out  = '0;
        n_out.unc = W'(1);
        w_sat  = 1'b0;
        w_m    = '0;
        w_mag  = '0;
        w_lim  = '0;
        case (w_f.cls)
            CL_ADDSUB: begin
                if (w_f.sum[W] != w_f.sum[W-1]) begin
                    w_sat = 1'b1;
                    n_out.value = w_f.sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                end else begin
                    n_out.value = w_f.sum[W-1:0];
                end
            end
            CL_MUL, CL_DIV: begin
                w_mag = (w_f.cls == CL_MUL) ? NB'(w_f.vmag >> F) : w_f.vq;
                w_lim = w_f.neg ? NB'({1'b1, {(W-1){1'b0}}}) : NB'({(W-1){1'b1}});
                if (w_mag > w_lim) begin
                    w_sat = 1'b1;
                    w_m   = w_lim[W-1:0];
                end else begin
                    w_m   = w_mag[W-1:0];
                end
                n_out.value = w_f.neg ? (~w_m + W'(1)) : w_m;
            end
            CL_DIVZ: begin
                n_out.unc    = '1;
                n_out.status = ST_DIV0;
            end
            CL_CMP: begin
                n_out.cmp = w_f.cmp;
            end
            default: begin
            end
        endcase
        if (w_f.cls == CL_ADDSUB || w_f.cls == CL_MUL || w_f.cls == CL_DIV) begin
            if (w_f.r[RB-1:W] != '0) begin
                w_sat = 1'b1;
                n_out.unc = '1;
            end else begin
                n_out.unc = (w_f.r[W-1:0] == '0) ? W'(1) : w_f.r[W-1:0];
            end
            if (w_sat) n_out.status = ST_SAT;
        end
    end

    assign w_adv = !r_vo || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vo <= 1'b0;
        else if (w_adv) r_vo <= r_vr[RootSt];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) r_out <= n_out;
    end

endmodule

### src/uncertainty_propagation_alu_unit.sv
// Top level of the uncertainty propagation ALU
//
// Input stream: s_axis_tdata carries the operands, s_axis_tuser the operation
// code. Output stream: m_axis_tdata carries value and uncertainty, m_axis_tuser
// the comparison flag and status. i_cfg_we writes sigma_limit from i_cfg_wdata.
// Add and subtract combine uncertainties in quadrature, multiply and divide use
// first-order propagation, comparisons test values with an equality band of
// sigma_limit combined deviations. Overflow saturates with status 1, a zero
// divisor gives status 2.
// Throughput is one item per cycle while the receiver is ready. Registers on the
// path: the front register, the queue entry, the product stage, the divider
// entry stage plus one stage per quotient bit of the 112-bit dividend, the
// squares stage, the root entry stage plus one stage per root bit (33) and the
// output register: 152 registers between an accepted input item and its result.
// Reset clears the pipeline valid bits and the queue and sets sigma_limit to
// 3. When the receiver stalls the whole back pipeline holds; the queue
// absorbs items the front already holds, then s_axis_tready falls.
module uncertainty_propagation_alu_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [3:0]    i_cfg_wdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // a_value [31:0], a_uncertainty [63:32], b_value [95:64], b_uncertainty [127:96]
    input  logic [127:0]  s_axis_tdata,
    // operation [3:0]
    input  logic [3:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // result_value [31:0], result_uncertainty [63:32]
    output logic [63:0]   m_axis_tdata,
    // compare_true [0], status [2:1]
    output logic [2:0]    m_axis_tuser
);
    import upa_pkg::*;

    logic [SigBits-1:0] r_sigma;
    logic    w_fv, w_fr, w_qv, w_qr;
    t_item   w_fi, w_qi;
    t_result w_res;

    // Hold the sigma limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sigma <= SigmaReset;
        else if (i_cfg_we) r_sigma <= i_cfg_wdata;
    end

    upa_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_op      (s_axis_tuser),
        .i_a_value (s_axis_tdata[31:0]),
        .i_a_unc   (s_axis_tdata[63:32]),
        .i_b_value (s_axis_tdata[95:64]),
        .i_b_unc   (s_axis_tdata[127:96]),
        .o_valid   (w_fv),
        .i_ready   (w_fr),
        .o_item    (w_fi)
    );

    upa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fv),
        .o_ready (w_fr),
        .i_item  (w_fi),
        .o_valid (w_qv),
        .i_ready (w_qr),
        .o_item  (w_qi)
    );

    upa_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sigma  (r_sigma),
        .i_valid  (w_qv),
        .o_ready  (w_qr),
        .i_item   (w_qi),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_res)
    );

    assign m_axis_tdata = {w_res.unc, w_res.value};
    assign m_axis_tuser = {w_res.status, w_res.cmp};

endmodule

### sim/testbench.sv
// Self-checking bench for the uncertainty propagation ALU: random and directed items
`timescale 1ns / 100ps
`default_nettype none

module testbench;
    import upa_pkg::*;

    typedef struct {
        logic [3:0]  op;
        logic [31:0] av;
        logic [31:0] au;
        logic [31:0] bv;
        logic [31:0] bu;
    } t_operands;

    typedef struct {
        logic [31:0] value;
        logic [31:0] unc;
        logic        cmp;
        logic [1:0]  status;
    } t_outcome;

    localparam logic [31:0] MaxPos = 32'h7fff_ffff;
    localparam logic [31:0] MaxNeg = 32'h8000_0000;
    localparam logic [31:0] AllOne = 32'hffff_ffff;
    localparam int          Latency = 200;
    localparam longint      CycleLimit = 400000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [3:0]    i_cfg_wdata = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [127:0]  s_axis_tdata = '0;
    logic [3:0]    s_axis_tuser = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [63:0]   m_axis_tdata;
    logic [2:0]    m_axis_tuser;

    t_operands     pending_items[$];
    t_outcome      expected_outcomes[$];
    logic [3:0]    sigma_limit = SigmaReset;
    int            mismatches = 0;
    longint        cycles = 0;
    int            send_gap = 0;
    int            recv_gap = 0;
    bit            stall_free = 1'b0;

    uncertainty_propagation_alu_unit dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Uncertainty as used: zero stands for one LSB
    function automatic logic [32:0] floor_unc(logic [31:0] u);
        return (u == 0) ? 33'd1 : {1'b0, u};
    endfunction

    function automatic logic [64:0] int_sqrt(logic [129:0] n);
        logic [64:0]  r;
        logic [64:0]  c;
        r = '0;
        for (int i = 64; i >= 0; i--) begin
            c = r | (65'd1 << i);
            if ({65'd0, c} * {65'd0, c} <= n) r = c;
        end
        return r;
    endfunction

    // Saturate a magnitude into a signed word
    function automatic logic [31:0] clamp_value(logic [127:0] mag, logic neg, ref bit sat);
        logic [127:0] lim;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (mag > lim) begin
            sat = 1'b1;
            mag = lim;
        end
        return neg ? 32'(-mag) : mag[31:0];
    endfunction

    function automatic logic [31:0] clamp_unc(logic [64:0] u, ref bit sat);
        if (u > 65'(AllOne)) begin
            sat = 1'b1;
            return AllOne;
        end
        return (u == 0) ? 32'd1 : u[31:0];
    endfunction

    function automatic logic [64:0] clip_word(logic [255:0] x);
        return (x > 256'h1_0000_0000) ? 65'h1_0000_0000 : x[64:0];
    endfunction

    function automatic t_outcome propagate(t_operands it);
        t_outcome     r;
        bit           sat;
        logic         an, bn;
        logic [63:0]  am, bm, sa, sb;
        longint       as, bs, s, d;
        logic [255:0] p, q, v, lhs, rhs;
        logic [64:0]  pc, qc;
        bit           eq, res;
        sat = 1'b0;
        r = '{value: '0, unc: 32'd1, cmp: 1'b0, status: ST_OK};
        an = it.av[31];
        bn = it.bv[31];
        as = longint'($signed(it.av));
        bs = longint'($signed(it.bv));
        am = an ? -as : as;
        bm = bn ? -bs : bs;
        sa = 64'(floor_unc(it.au));
        sb = 64'(floor_unc(it.bu));
        case (it.op)
            OP_ADD, OP_SUB: begin
                s = (it.op == OP_ADD) ? as + bs : as - bs;
                r.value = clamp_value(128'(s < 0 ? -s : s), s < 0, sat);
                r.unc = clamp_unc(int_sqrt(130'(sa * sa) + 130'(sb * sb)), sat);
            end
            OP_MUL: begin
                p = (256'(bm) * sa) >> FracBits;
                q = (256'(am) * sb) >> FracBits;
                v = (256'(am) * bm) >> FracBits;
                r.value = clamp_value(v[127:0] | 128'(|v[255:128]) << 100, an != bn, sat);
                pc = clip_word(p);
                qc = clip_word(q);
                r.unc = clamp_unc(int_sqrt(130'(pc) * pc + 130'(qc) * qc), sat);
            end
            OP_DIV: begin
                if (bm == 0) begin
                    r.unc = AllOne;
                    r.status = ST_DIV0;
                end else begin
                    p = (256'(sa) << FracBits) / bm;
                    q = ((256'(am) * sb) << FracBits) / (256'(bm) * bm);
                    v = (256'(am) << FracBits) / bm;
                    r.value = clamp_value(v[127:0], an != bn, sat);
                    pc = clip_word(p);
                    qc = clip_word(q);
                    r.unc = clamp_unc(int_sqrt(130'(pc) * pc + 130'(qc) * qc), sat);
                end
            end
            OP_LT, OP_GT, OP_LE, OP_GE, OP_EQ, OP_NE: begin
                d = as - bs;
                lhs = 256'(d < 0 ? -d : d);
                lhs = lhs * lhs;
                rhs = (256'(sa) * sa + 256'(sb) * sb) * (sigma_limit * sigma_limit);
                eq = rhs >= lhs;
                case (it.op)
                    OP_LT:   res = as < bs;
                    OP_GT:   res = as > bs;
                    OP_LE:   res = (as < bs) || eq;
                    OP_GE:   res = (as > bs) || eq;
                    OP_EQ:   res = eq;
                    default: res = !eq;
                endcase
                r.cmp = res;
            end
            default: ;
        endcase
        if (sat && r.status == ST_OK) r.status = ST_SAT;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
        mismatches++;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return MaxPos;
            1:       return MaxNeg;
            2:       return 32'($signed($urandom_range(0, 8)) - 4) << FracBits;
            3:       return 32'($signed($urandom_range(0, 2000)) - 1000);
            4:       return $urandom() >> $urandom_range(0, 31);
            5:       return -($urandom() >> $urandom_range(0, 31));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_unc();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return AllOne;
            2:       return $urandom_range(0, 8);
            default: return $urandom() >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic t_operands mk(logic [3:0] op, logic [31:0] av, logic [31:0] au,
                                     logic [31:0] bv, logic [31:0] bu);
        t_operands it;
        it.op = op;
        it.av = av;
        it.au = au;
        it.bv = bv;
        it.bu = bu;
        return it;
    endfunction

    // Driver: present the next pending item after a random gap, or with no gap in stall-free phases
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_outcomes.push_back(propagate(pending_items.pop_front()));
                send_gap = stall_free ? 0 : $urandom_range(0, 5);
            end
            if ((!s_axis_tvalid || s_axis_tready) ) begin
                if (send_gap > 0 || pending_items.size() == 0
                        || (s_axis_tvalid && s_axis_tready && pending_items.size() == 0)) begin
                    if (send_gap > 0) send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= pending_items[0].op;
                    s_axis_tdata  <= {pending_items[0].bu, pending_items[0].bv,
                                      pending_items[0].au, pending_items[0].av};
                end
            end
        end
    end

    // Monitor: compare each result item with the oldest expectation
    always @(posedge i_clk) begin
        t_outcome want;
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_outcomes.size() == 0) begin
                report_mismatch("unexpected item", m_axis_tdata[31:0], '0);
            end else begin
                want = expected_outcomes.pop_front();
                if (m_axis_tdata[31:0] !== want.value)
                    report_mismatch("value", m_axis_tdata[31:0], want.value);
                if (m_axis_tdata[63:32] !== want.unc)
                    report_mismatch("uncertainty", m_axis_tdata[63:32], want.unc);
                if (m_axis_tuser[0] !== want.cmp)
                    report_mismatch("compare", 32'(m_axis_tuser[0]), 32'(want.cmp));
                if (m_axis_tuser[2:1] !== want.status)
                    report_mismatch("status", 32'(m_axis_tuser[2:1]), 32'(want.status));
            end
        end
        if (stall_free) begin
            m_axis_tready <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (m_axis_tvalid && m_axis_tready) recv_gap = $urandom_range(0, 5);
        end
        if (cycles > CycleLimit) begin
            $display("timeout");
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic drain();
        wait (pending_items.size() == 0 && !s_axis_tvalid);
        wait (expected_outcomes.size() == 0);
        repeat (Latency) @(posedge i_clk);
    endtask

    task automatic write_sigma(logic [3:0] k);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= k;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sigma_limit = k;
    endtask

    task automatic queue_random(int n);
        t_operands it;
        for (int i = 0; i < n; i++) begin
            it = mk($urandom_range(0, 15) < 14 ? 4'($urandom_range(0, 9))
                                               : 4'($urandom_range(10, 15)),
                    rand_value(), rand_unc(), rand_value(), rand_unc());
            if ($urandom_range(0, 7) == 0) it.bv = it.av + $urandom_range(0, 64);
            pending_items.push_back(it);
        end
    endtask

    initial begin
        logic [3:0] settings[4] = '{4'd0, 4'd15, 4'd1, 4'd7};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every operation, zero divisor, spare codes
        for (int op = 0; op <= 9; op++)
            pending_items.push_back(mk(4'(op), MaxPos, AllOne, MaxNeg, AllOne));
        pending_items.push_back(mk(OP_ADD, MaxPos, 0, MaxPos, 0));
        pending_items.push_back(mk(OP_SUB, MaxNeg, 0, 32'd1, 0));
        pending_items.push_back(mk(OP_MUL, MaxNeg, 32'd5, MaxNeg, 32'd7));
        pending_items.push_back(mk(OP_MUL, 32'd0, 0, 32'd0, 0));
        pending_items.push_back(mk(OP_DIV, 32'h0001_0000, 32'd1, 32'd0, 32'd1));
        pending_items.push_back(mk(OP_DIV, MaxNeg, AllOne, 32'd1, AllOne));
        pending_items.push_back(mk(OP_DIV, 32'h0003_0000, 32'h100, 32'hffff_0000, 0));
        pending_items.push_back(mk(OP_EQ, 32'd10, 32'd1, 32'd13, 32'd1));
        pending_items.push_back(mk(OP_EQ, 32'd10, 0, 32'd10, 0));
        pending_items.push_back(mk(4'd10, 32'd1, 32'd1, 32'd1, 32'd1));
        pending_items.push_back(mk(4'd15, AllOne, AllOne, AllOne, AllOne));
        queue_random(150);
        drain();

        // Random phases under several equality bands, extremes included
        foreach (settings[k]) begin
            write_sigma(settings[k]);
            if (settings[k] == 4'd0) begin
                pending_items.push_back(mk(OP_EQ, 32'd10, 0, 32'd10, 0));
                pending_items.push_back(mk(OP_NE, 32'd10, 0, 32'd11, 0));
            end
            stall_free = (k == 2);
            queue_random(150);
            drain();
        end
        stall_free = 1'b0;

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

`default_nettype wire
